>>> hdl/eci_pkg.sv
// Shared types, constants and arithmetic helpers for the easing-curve interpolator.
package eci_pkg;

  localparam int QF = 28;
  localparam int QW = 34;
  localparam int PW = 2 * QW;
  localparam int PROGRESS_FRAC_BITS_DEF = 15;

  localparam int SQ_STEPS  = 29;
  localparam int SQ_STAGES = (SQ_STEPS + 1) / 2;
  localparam int SQW       = 58;
  localparam int PIPE_DEPTH = 3 + 5 + SQ_STAGES + 3;

  typedef logic signed [QW-1:0] q_t;
  typedef logic signed [PW-1:0] prod_t;

  localparam q_t QONE = q_t'(1) <<< QF;
  localparam q_t HALF = QONE >>> 1;
  localparam q_t Q2   = QONE * 2;
  localparam q_t Q4   = QONE * 4;
  localparam q_t Q6   = QONE * 6;
  localparam q_t Q8   = QONE * 8;
  localparam q_t Q9   = QONE * 9;
  localparam q_t Q10  = QONE * 10;
  localparam q_t Q21  = QONE * 21;
  localparam q_t OFS_3_4   = (QONE >>> 2) * 3;
  localparam q_t OFS_15_16 = (QONE >>> 4) * 15;
  localparam q_t OFS_63_64 = (QONE >>> 6) * 63;

  localparam logic [63:0] C1_RAW = ((64'd170158 << QF) + 64'd50000) / 64'd100000;
  localparam logic [63:0] C2_RAW = ((64'd259490950 << QF) + 64'd50000000) / 64'd100000000;
  localparam q_t C1  = q_t'(C1_RAW);
  localparam q_t C2  = q_t'(C2_RAW);
  localparam q_t C3  = C1 + QONE;
  localparam q_t C2P = C2 + QONE;

  localparam logic [1:0] REG_KIND = 2'd0;
  localparam logic [1:0] REG_DIR  = 2'd1;

  typedef enum logic [2:0] {
    K_BACK   = 3'd0,
    K_BOUNCE = 3'd1,
    K_CIRC   = 3'd2,
    K_QUINT  = 3'd3,
    K_CUBIC  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    D_IN    = 2'd0,
    D_OUT   = 2'd1,
    D_INOUT = 2'd2
  } dir_t;

  typedef struct packed {
    kind_t              kind;
    dir_t               dir;
    logic               lo;
    logic signed [31:0] sval;
    logic signed [32:0] diff;
  } side_t;

  typedef struct packed {
    side_t side;
    q_t    f;
  } item_t;

  typedef struct packed {
    logic [SQW-1:0] v;
    logic [SQW-1:0] res;
  } sq_t;

  // round to nearest, ties away from zero, dropping n fraction bits
  function automatic prod_t rnd(input prod_t x, input int n);
    logic [PW-1:0] m;
    logic [PW-1:0] one;
    one = {{(PW-1){1'b0}}, 1'b1};
    m = x[PW-1] ? -x : x;
    m = (m + (one << (n - 1))) >> n;
    return x[PW-1] ? -prod_t'(m) : prod_t'(m);
  endfunction

  function automatic q_t mulq(input q_t a, input q_t b);
    prod_t p;
    p = a * b;
    return q_t'(rnd(p, QF));
  endfunction

  function automatic q_t halfq(input q_t a);
    return q_t'(rnd(prod_t'(a), 1));
  endfunction

  // one restoring square-root step, bit weight 4^(SQ_STEPS-1-i)
  function automatic sq_t sq_step(input sq_t s, input int i);
    logic [SQW-1:0] b;
    sq_t o;
    b = {{(SQW-1){1'b0}}, 1'b1} << (2 * (SQ_STEPS - 1) - 2 * i);
    o = s;
    if (s.v >= s.res + b) begin
      o.v   = s.v - (s.res + b);
      o.res = (s.res >> 1) + b;
    end else begin
      o.res = s.res >> 1;
    end
    return o;
  endfunction

endpackage

>>> hdl/eci_front.sv
// Front end: progress clipping, curve operand and bounce segment selection.
module eci_front #(
  parameter int PROGRESS_FRAC_BITS = eci_pkg::PROGRESS_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [15:0]         progress,
  input  logic signed [31:0]  start_value,
  input  logic signed [31:0]  end_value,
  input  eci_pkg::kind_t      kind,
  input  eci_pkg::dir_t       dir,
  output logic                out_valid,
  output eci_pkg::side_t      out_side,
  output eci_pkg::q_t         out_op,
  output logic [1:0]          out_zone
);
  import eci_pkg::*;

  logic               v1, v2;
  q_t                 t1;
  logic signed [31:0] s1, e1;
  kind_t              k1;
  dir_t               d1;
  side_t              side2;
  q_t                 op2;

  q_t    pe, onep, pc, t_next;
  logic  lo;
  q_t    op_next;
  q_t    x11, w_next;
  logic [1:0] zone_next;

  always_comb begin
    pe     = q_t'(progress);
    onep   = q_t'(1) <<< PROGRESS_FRAC_BITS;
    pc     = (pe > onep) ? onep : pe;
    t_next = pc <<< (QF - PROGRESS_FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    t1 <= t_next;
    s1 <= start_value;
    e1 <= end_value;
    k1 <= kind;
    d1 <= dir;
  end

  always_comb begin
    lo = t1 < HALF;
    case (k1)
      K_BACK, K_CIRC: begin
        case (d1)
          D_IN:    op_next = t1;
          D_OUT:   op_next = t1 - QONE;
          default: op_next = lo ? (t1 <<< 1) :
                             ((k1 == K_BACK) ? (t1 <<< 1) - Q2 : Q2 - (t1 <<< 1));
        endcase
      end
      K_BOUNCE: begin
        // operand is the argument of the bounce-out curve
        case (d1)
          D_IN:    op_next = QONE - t1;
          D_OUT:   op_next = t1;
          default: op_next = lo ? QONE - (t1 <<< 1) : (t1 <<< 1) - QONE;
        endcase
      end
      default: begin
        case (d1)
          D_IN:    op_next = t1;
          D_OUT:   op_next = QONE - t1;
          default: op_next = lo ? t1 : Q2 - (t1 <<< 1);
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    side2.kind <= k1;
    side2.dir  <= d1;
    side2.lo   <= lo;
    side2.sval <= s1;
    side2.diff <= {e1[31], e1} - {s1[31], s1};
    op2        <= op_next;
  end

  always_comb begin
    x11 = (op2 <<< 3) + (op2 <<< 1) + op2;
    if (side2.kind != K_BOUNCE) begin
      w_next = op2;
      zone_next = 2'd0;
    end else if (x11 < Q4) begin
      w_next = x11;
      zone_next = 2'd0;
    end else if (x11 < Q8) begin
      w_next = x11 - Q6;
      zone_next = 2'd1;
    end else if (x11 < Q10) begin
      w_next = x11 - Q9;
      zone_next = 2'd2;
    end else begin
      w_next = (x11 <<< 1) - Q21;
      zone_next = 2'd3;
    end
  end

  always_ff @(posedge clk) begin
    out_side <= side2;
    out_op   <= w_next;
    out_zone <= zone_next;
  end

endmodule

>>> hdl/eci_powers.sv
// Multiplier chain: powers, back and bounce terms, and the eased fraction.
module eci_powers (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  eci_pkg::side_t  in_side,
  input  eci_pkg::q_t     in_op,
  input  logic [1:0]      in_zone,
  output logic            out_valid,
  output eci_pkg::item_t  out_item,
  output eci_pkg::q_t     out_rad
);
  import eci_pkg::*;

  logic  v1, v2, v3, v4;
  side_t sd1, sd2, sd3, sd4;
  q_t    op1, op2, op3;
  q_t    sq1, sq2, sq3, sq4;
  q_t    bo1, bo2, bo3, bo4;
  q_t    m1, m2;
  q_t    p3_2, p3_3, p3_4;
  q_t    p4_3, a3, b3, x3;
  q_t    p5_4, fb4;

  prod_t wsq;
  q_t    bo_next, fb_next, f_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  always_comb begin
    wsq = in_op * in_op;
    case (in_zone)
      2'd0:    bo_next = q_t'(rnd(wsq, QF + 4));
      2'd1:    bo_next = q_t'(rnd(wsq, QF + 4)) + OFS_3_4;
      2'd2:    bo_next = q_t'(rnd(wsq, QF + 4)) + OFS_15_16;
      default: bo_next = q_t'(rnd(wsq, QF + 6)) + OFS_63_64;
    endcase
  end

  always_ff @(posedge clk) begin
    sd1 <= in_side;
    op1 <= in_op;
    sq1 <= q_t'(rnd(wsq, QF));
    bo1 <= bo_next;
    m1  <= mulq(C2P, in_op);
  end

  always_ff @(posedge clk) begin
    sd2  <= sd1;
    op2  <= op1;
    sq2  <= sq1;
    bo2  <= bo1;
    p3_2 <= mulq(sq1, op1);
    m2   <= sd1.lo ? m1 - C2 : m1 + C2;
  end

  always_ff @(posedge clk) begin
    sd3  <= sd2;
    op3  <= op2;
    sq3  <= sq2;
    bo3  <= bo2;
    p3_3 <= p3_2;
    p4_3 <= mulq(p3_2, op2);
    a3   <= mulq(C3, p3_2);
    b3   <= mulq(C1, sq2);
    x3   <= mulq(sq2, m2);
  end

  always_comb begin
    case (sd3.dir)
      D_IN:    fb_next = a3 - b3;
      D_OUT:   fb_next = QONE + a3 + b3;
      default: fb_next = sd3.lo ? halfq(x3) : halfq(x3 + Q2);
    endcase
  end

  always_ff @(posedge clk) begin
    sd4  <= sd3;
    sq4  <= sq3;
    bo4  <= bo3;
    p3_4 <= p3_3;
    p5_4 <= mulq(p4_3, op3);
    fb4  <= fb_next;
  end

  always_comb begin
    case (sd4.kind)
      K_BACK:  f_next = fb4;
      K_BOUNCE: begin
        case (sd4.dir)
          D_IN:    f_next = QONE - bo4;
          D_OUT:   f_next = bo4;
          default: f_next = sd4.lo ? halfq(QONE - bo4) : halfq(bo4) + HALF;
        endcase
      end
      K_CIRC:  f_next = '0;  // filled in after the square root
      K_QUINT: begin
        case (sd4.dir)
          D_IN:    f_next = p5_4;
          D_OUT:   f_next = QONE - p5_4;
          default: f_next = sd4.lo ? (p5_4 <<< 4) : QONE - halfq(p5_4);
        endcase
      end
      default: begin
        case (sd4.dir)
          D_IN:    f_next = p3_4;
          D_OUT:   f_next = QONE - p3_4;
          default: f_next = sd4.lo ? (p3_4 <<< 2) : QONE - halfq(p3_4);
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_item.side <= sd4;
    out_item.f    <= f_next;
    out_rad       <= QONE - sq4;
  end

endmodule

>>> hdl/eci_sqrt.sv
// Pipelined restoring square root, two result bits per stage (one in the last), with sideband.
module eci_sqrt (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  eci_pkg::item_t  in_item,
  input  eci_pkg::q_t     in_rad,
  output logic            out_valid,
  output eci_pkg::item_t  out_item,
  output eci_pkg::q_t     out_root
);
  import eci_pkg::*;

  logic  vld [SQ_STAGES];
  item_t itm [SQ_STAGES];
  sq_t   st  [SQ_STAGES];

  for (genvar j = 0; j < SQ_STAGES; j++) begin : g_stage
    sq_t   s_in, s_out;
    logic  v_in;
    item_t i_in;

    if (j == 0) begin : g_first
      // radicand scaled so the root lands in Q1.28
      assign s_in.v   = {{(SQW-QF-1){1'b0}}, in_rad[QF:0]} << QF;
      assign s_in.res = '0;
      assign v_in     = in_valid;
      assign i_in     = in_item;
    end else begin : g_rest
      assign s_in = st[j-1];
      assign v_in = vld[j-1];
      assign i_in = itm[j-1];
    end

    always_comb begin
      s_out = sq_step(s_in, 2 * j);
      if (2 * j + 1 < SQ_STEPS) begin
        s_out = sq_step(s_out, 2 * j + 1);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else begin
        vld[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      st[j]  <= s_out;
      itm[j] <= i_in;
    end
  end

  assign out_valid = vld[SQ_STAGES-1];
  assign out_item  = itm[SQ_STAGES-1];
  assign out_root  = q_t'(st[SQ_STAGES-1].res[QW-1:0]);

endmodule

>>> hdl/eci_blend.sv
// Circular finish, interpolation product, rounding and saturation.
module eci_blend (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  eci_pkg::item_t     in_item,
  input  eci_pkg::q_t        in_root,
  output logic               done,
  output logic signed [31:0] eased_value,
  output logic               saturated
);
  import eci_pkg::*;

  localparam logic signed [39:0] MAXV = 40'sd2147483647;
  localparam logic signed [39:0] MINV = -40'sd2147483648;

  logic               v1, v2;
  q_t                 f1;
  logic signed [31:0] s1, s2;
  logic signed [32:0] diff1;
  prod_t              prod2;

  q_t                 f_next;
  prod_t              rr;
  logic signed [39:0] r;

  always_comb begin
    if (in_item.side.kind == K_CIRC) begin
      case (in_item.side.dir)
        D_IN:    f_next = QONE - in_root;
        D_OUT:   f_next = in_root;
        default: f_next = in_item.side.lo ? halfq(QONE - in_root) : halfq(in_root + QONE);
      endcase
    end else begin
      f_next = in_item.f;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    f1    <= f_next;
    s1    <= in_item.side.sval;
    diff1 <= in_item.side.diff;
    s2    <= s1;
    prod2 <= diff1 * f1;
  end

  always_comb begin
    rr = rnd(prod2, QF);
    r  = 40'(s2) + 40'(rr);
  end

  always_ff @(posedge clk) begin
    if (r > MAXV) begin
      eased_value <= 32'sh7fffffff;
      saturated   <= 1'b1;
    end else if (r < MINV) begin
      eased_value <= 32'sh80000000;
      saturated   <= 1'b1;
    end else begin
      eased_value <= r[31:0];
      saturated   <= 1'b0;
    end
  end

endmodule

>>> hdl/easing_curve_interpolator.sv
// Top level of the easing-curve interpolator.
// Usage:
//   Input: a transfer happens on each rising edge with start high and busy low.
//   busy stays low, so a new progress/start/end item may be offered every cycle.
//   Configuration: cfg_index 0 selects curve_kind, 1 selects ease_direction;
//   a transfer happens when cfg_valid and cfg_ready are high (cfg_ready is
//   always high). Write only while no item is in flight.
//   Output: done is high for one cycle with eased_value and saturated valid.
//   There is no back-pressure on the result side.
// Pipeline and rate:
//   A pipeline of 26 registers lies between the start transfer and done. One
//   item per clock sustained; the depth is set by the 15-stage square-root
//   unit (two root bits per stage, one in the last) and the five-stage
//   multiplier chain.
// Reset:
//   rst (synchronous) empties the pipeline, sets curve_kind to cubic and
//   ease_direction to ease in.
module easing_curve_interpolator #(
  parameter int PROGRESS_FRAC_BITS = eci_pkg::PROGRESS_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        progress,
  input  logic signed [31:0] start_value,
  input  logic signed [31:0] end_value,
  output logic               done,
  output logic signed [31:0] eased_value,
  output logic               saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [2:0]         cfg_data
);
  import eci_pkg::*;

  kind_t curve_kind;
  dir_t  ease_direction;

  logic  fr_valid;
  side_t fr_side;
  q_t    fr_op;
  logic [1:0] fr_zone;
  logic  pw_valid;
  item_t pw_item;
  q_t    pw_rad;
  logic  sq_valid;
  item_t sq_item;
  q_t    sq_root;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // unknown codes fold onto cubic and in-out
  always_ff @(posedge clk) begin
    if (rst) begin
      curve_kind     <= K_CUBIC;
      ease_direction <= D_IN;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_KIND) begin
        curve_kind <= (cfg_data inside {[3'd5:3'd7]}) ? K_CUBIC : kind_t'(cfg_data);
      end else if (cfg_index == REG_DIR) begin
        ease_direction <= (cfg_data[1:0] == 2'd3) ? D_INOUT : dir_t'(cfg_data[1:0]);
      end
    end
  end

  eci_front #(.PROGRESS_FRAC_BITS(PROGRESS_FRAC_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (start && !busy),
    .progress    (progress),
    .start_value (start_value),
    .end_value   (end_value),
    .kind        (curve_kind),
    .dir         (ease_direction),
    .out_valid   (fr_valid),
    .out_side    (fr_side),
    .out_op      (fr_op),
    .out_zone    (fr_zone)
  );

  eci_powers u_powers (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_side   (fr_side),
    .in_op     (fr_op),
    .in_zone   (fr_zone),
    .out_valid (pw_valid),
    .out_item  (pw_item),
    .out_rad   (pw_rad)
  );

  eci_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pw_valid),
    .in_item   (pw_item),
    .in_rad    (pw_rad),
    .out_valid (sq_valid),
    .out_item  (sq_item),
    .out_root  (sq_root)
  );

  eci_blend u_blend (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (sq_valid),
    .in_item     (sq_item),
    .in_root     (sq_root),
    .done        (done),
    .eased_value (eased_value),
    .saturated   (saturated)
  );

endmodule

>>> hdl/eci_checker.sv
// Port-level checks for the easing-curve interpolator, bound to the top level.
module eci_props (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        saturated,
  input logic [31:0] eased_value
);
  import eci_pkg::*;

  a_sat_clip: assert property (@(posedge clk) disable iff (rst)
    done && saturated |-> eased_value == 32'h7fffffff || eased_value == 32'h80000000)
    else $error("saturated result not at a range limit");

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_DEPTH))
    else $error("result without a matching input transfer");

  a_in_out: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##PIPE_DEPTH done)
    else $error("input transfer produced no result");

  a_rst_quiet: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result strobe straight after reset");

endmodule

bind easing_curve_interpolator eci_props u_eci_props (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .saturated   (saturated),
  .eased_value (eased_value)
);
